@@ hdl/kms_pkg.sv @@
// Shared types, constants and the key-code table for the keyboard matrix scanner.
`default_nettype none
package kms_pkg;

    localparam int ROWS     = 8;
    localparam int ROW_BITS = 3;
    localparam int COLS     = 5;
    localparam logic [COLS-1:0] ROW_IDLE = 5'h1f;

    typedef enum logic [1:0] {
        MODE_PRESS   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_READ    = 2'd2
    } mode_t;

    typedef struct packed {
        logic                hit;
        logic [ROW_BITS-1:0] row;
        logic [COLS-1:0]     mask;
    } key_t;

    // Matrix update command from the input stage.
    typedef struct packed {
        logic       apply;
        logic       down;
        logic       clear_all;
        key_t       first;
        key_t       second;
    } cmd_t;

    function automatic key_t key_lookup(input logic [7:0] code);
        key_t k;
        k.hit = 1'b1;
        unique case (code)
            "1": begin k.row = 3'd4; k.mask = 5'd1;  end
            "2": begin k.row = 3'd4; k.mask = 5'd2;  end
            "3": begin k.row = 3'd4; k.mask = 5'd4;  end
            "4": begin k.row = 3'd4; k.mask = 5'd8;  end
            "5": begin k.row = 3'd4; k.mask = 5'd16; end
            "6": begin k.row = 3'd3; k.mask = 5'd16; end
            "7": begin k.row = 3'd3; k.mask = 5'd8;  end
            "8": begin k.row = 3'd3; k.mask = 5'd4;  end
            "9": begin k.row = 3'd3; k.mask = 5'd2;  end
            "0": begin k.row = 3'd3; k.mask = 5'd1;  end
            "q": begin k.row = 3'd5; k.mask = 5'd1;  end
            "w": begin k.row = 3'd5; k.mask = 5'd2;  end
            "e": begin k.row = 3'd5; k.mask = 5'd4;  end
            "r": begin k.row = 3'd5; k.mask = 5'd8;  end
            "t": begin k.row = 3'd5; k.mask = 5'd16; end
            "y": begin k.row = 3'd2; k.mask = 5'd16; end
            "u": begin k.row = 3'd2; k.mask = 5'd8;  end
            "i": begin k.row = 3'd2; k.mask = 5'd4;  end
            "o": begin k.row = 3'd2; k.mask = 5'd2;  end
            "p": begin k.row = 3'd2; k.mask = 5'd1;  end
            "a": begin k.row = 3'd6; k.mask = 5'd1;  end
            "s": begin k.row = 3'd6; k.mask = 5'd2;  end
            "d": begin k.row = 3'd6; k.mask = 5'd4;  end
            "f": begin k.row = 3'd6; k.mask = 5'd8;  end
            "g": begin k.row = 3'd6; k.mask = 5'd16; end
            "h": begin k.row = 3'd1; k.mask = 5'd16; end
            "j": begin k.row = 3'd1; k.mask = 5'd8;  end
            "k": begin k.row = 3'd1; k.mask = 5'd4;  end
            "l": begin k.row = 3'd1; k.mask = 5'd2;  end
            "E": begin k.row = 3'd1; k.mask = 5'd1;  end // enter
            "C": begin k.row = 3'd7; k.mask = 5'd1;  end // caps shift
            "z": begin k.row = 3'd7; k.mask = 5'd2;  end
            "x": begin k.row = 3'd7; k.mask = 5'd4;  end
            "c": begin k.row = 3'd7; k.mask = 5'd8;  end
            "v": begin k.row = 3'd7; k.mask = 5'd16; end
            "b": begin k.row = 3'd0; k.mask = 5'd16; end
            "n": begin k.row = 3'd0; k.mask = 5'd8;  end
            "m": begin k.row = 3'd0; k.mask = 5'd4;  end
            "S": begin k.row = 3'd0; k.mask = 5'd2;  end // symbol shift
            " ": begin k.row = 3'd0; k.mask = 5'd1;  end // space
            default:
            begin
                k.hit  = 1'b0;
                k.row  = '0;
                k.mask = '0;
            end
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

@@ hdl/kms_key_decode.sv @@
// Key-code decoder: maps one code to its row and column mask.
`default_nettype none
module kms_key_decode
    import kms_pkg::*;
(
    input  wire logic [7:0] code,
    output key_t            key
);

    assign key = key_lookup(code);

endmodule
`default_nettype wire

@@ hdl/kms_matrix.sv @@
// Key matrix state: press/release update and row-select read.
`default_nettype none
module kms_matrix
    import kms_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    input  wire logic [ROWS-1:0]   row_select,
    output logic      [COLS-1:0]   column_data
);

    logic [COLS-1:0] rows_reg  [ROWS];
    logic [COLS-1:0] rows_next [ROWS];

    always_comb
    begin
        logic [COLS-1:0] m;
        for (int r = 0; r < ROWS; r++)
        begin
            m = '0;
            if (cmd.first.hit && cmd.first.row == ROW_BITS'(r))
                m = m | cmd.first.mask;
            if (cmd.second.hit && cmd.second.row == ROW_BITS'(r))
                m = m | cmd.second.mask;
            rows_next[r] = rows_reg[r];
            if (cmd.apply)
            begin
                priority if (cmd.clear_all)
                    rows_next[r] = ROW_IDLE;
                else if (cmd.down)
                    rows_next[r] = rows_reg[r] & ~m;
                else
                    rows_next[r] = rows_reg[r] | m;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
                rows_reg[r] <= ROW_IDLE;
        end
        else
        begin
            for (int r = 0; r < ROWS; r++)
                rows_reg[r] <= rows_next[r];
        end
    end

    // bit 7 of the select byte picks row 0
    always_comb
    begin
        column_data = ROW_IDLE;
        for (int r = 0; r < ROWS; r++)
        begin
            if (!row_select[ROWS-1-r])
                column_data = column_data & rows_reg[r];
        end
    end

endmodule
`default_nettype wire

@@ hdl/keyboard_matrix_scan.sv @@
// Top level of the 8x5 keyboard matrix scanner with stream input and output.
//
//  channel | dir | tdata (low bit up)                          | tuser     | beats
//  s_axis  | in  | first_key[7:0] second_key[15:8] row_sel[23:16] | mode[1:0] | one command
//  m_axis  | out | column_data[4:0], zeros above                 | -         | one per read
//
//  A beat lands in the input register and is decoded there; a press or release is applied
//  in the next cycle. One beat per cycle is sustained while no read waits to be registered.
//  Press, release and mode 3 beats give no output beat.
//  A read waits in the input register only while the output register holds an
//  untaken result; the input side then stalls until m_axis_tready.
//  rst_n (async, active low) sets every row to 0x1f and empties both registers.
`default_nettype none
module keyboard_matrix_scan
    import kms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // first_key, second_key, row_select
    input  wire logic [1:0]  s_axis_tuser,  // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata   // column_data, zero fill
);

    // input register
    logic            in_valid_reg, in_valid_next;
    logic [1:0]      mode_reg;
    logic [7:0]      first_reg, second_reg, sel_reg;

    // result register
    logic            out_valid_reg, out_valid_next;
    logic [COLS-1:0] col_reg;

    logic            is_read, is_press, is_release;
    logic            out_free, stage_fire, in_beat;
    key_t            first_key, second_key;
    cmd_t            cmd;
    logic [COLS-1:0] col_data;

    assign is_read    = (mode_reg == MODE_READ);
    assign is_press   = (mode_reg == MODE_PRESS);
    assign is_release = (mode_reg == MODE_RELEASE);

    assign out_free   = !out_valid_reg || m_axis_tready;
    // only a read needs room in the result register
    assign stage_fire = in_valid_reg && (!is_read || out_free);
    assign s_axis_tready = !in_valid_reg || stage_fire;
    assign in_beat    = s_axis_tvalid && s_axis_tready;

    kms_key_decode u_dec_first
    (
        .code (first_reg),
        .key  (first_key)
    );

    kms_key_decode u_dec_second
    (
        .code (second_reg),
        .key  (second_key)
    );

    always_comb
    begin
        cmd.apply     = stage_fire && (is_press || is_release);
        cmd.down      = is_press;
        // release naming no key resets the whole matrix
        cmd.clear_all = is_release && (first_reg == 8'd0) && (second_reg == 8'd0);
        cmd.first     = first_key;
        cmd.second    = second_key;
    end

    kms_matrix u_matrix
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .row_select  (sel_reg),
        .column_data (col_data)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_beat)
            in_valid_next = 1'b1;
        else if (stage_fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (stage_fire && is_read)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            mode_reg   <= s_axis_tuser;
            first_reg  <= s_axis_tdata[7:0];
            second_reg <= s_axis_tdata[15:8];
            sel_reg    <= s_axis_tdata[23:16];
        end
        if (stage_fire && is_read)
            col_reg <= col_data;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, col_reg};

endmodule
`default_nettype wire

@@ hdl/kms_checker.sv @@
// Port-level checker for the keyboard matrix scanner, bound to the top level.
`default_nettype none
module kms_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata
);

    // output beat holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // input only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:5] == 3'b000)
        else $error("nonzero fill bits in output beat");

endmodule

bind keyboard_matrix_scan kms_checker u_kms_checker (.*);
`default_nettype wire

@@ tb/tb_keyboard_matrix_scan.sv @@
// Testbench for keyboard_matrix_scan: directed and random key press, release and read beats.
module tb_keyboard_matrix_scan
    import kms_pkg::*;
;

    // Mode 3 is outside mode_t; the block must swallow it without effect.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Key codes in table order: eight groups of five, one group per matrix row.
    localparam string KEY_LAYOUT = "1234567890qwertyuiopasdfghjklECzxcvbnmS ";

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASE_ITEMS    = 475;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = MODE_PRESS;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    int in_idle_pct  = 16;
    int out_idle_pct = 59;
    int quiet_cycles = 0;

    // Tracks the matrix as the block should see it and the read answers still owed.
    class KeyMatrixScoreboard;
        logic [COLS-1:0] matrix_rows [ROWS];
        logic [COLS-1:0] owed_columns [$];
        int              mismatch_count;
        int              group_row [8] = '{4, 3, 5, 2, 6, 1, 7, 0};

        function new();
            mismatch_count = 0;
            clear_matrix();
        endfunction

        function void clear_matrix();
            foreach (matrix_rows[i])
                matrix_rows[i] = ROW_IDLE;
        endfunction

        // Even groups run mask 1..16 along the layout, odd groups 16..1.
        function void hit_keys(logic [7:0] first_code, logic [7:0] second_code, bit down);
            int              grp;
            int              pos;
            int              row;
            logic [COLS-1:0] mask;
            for (int i = 0; i < 40; i++)
            begin
                if (KEY_LAYOUT[i] == first_code || KEY_LAYOUT[i] == second_code)
                begin
                    grp  = i / 5;
                    pos  = i % 5;
                    row  = group_row[grp];
                    mask = (grp % 2) ? (5'd16 >> pos) : (5'd1 << pos);
                    if (down)
                        matrix_rows[row] = matrix_rows[row] & ~mask;
                    else
                        matrix_rows[row] = matrix_rows[row] | mask;
                end
            end
        endfunction

        function void note_command(logic [1:0] mode, logic [7:0] first_code,
                                   logic [7:0] second_code, logic [7:0] row_sel);
            logic [COLS-1:0] columns;
            if (mode == MODE_PRESS)
                hit_keys(first_code, second_code, 1'b1);
            else if (mode == MODE_RELEASE)
            begin
                // release naming no key lets go of everything
                if (first_code == 8'd0 && second_code == 8'd0)
                    clear_matrix();
                else
                    hit_keys(first_code, second_code, 1'b0);
            end
            else if (mode == MODE_READ)
            begin
                columns = ROW_IDLE;
                for (int i = 0; i < ROWS; i++)
                    if (!row_sel[7 - i])
                        columns &= matrix_rows[i];
                owed_columns.push_back(columns);
            end
        endfunction

        function void check_column(logic [7:0] beat);
            logic [COLS-1:0] want;
            if (owed_columns.size() == 0)
            begin
                $display("%0t: unexpected output beat, expected none, actual 0x%02h",
                         $time, beat);
                mismatch_count++;
            end
            else
            begin
                want = owed_columns.pop_front();
                if (beat !== {3'b000, want})
                begin
                    $display("%0t: column_data mismatch, expected 0x%02h, actual 0x%02h",
                             $time, {3'b000, want}, beat);
                    mismatch_count++;
                end
            end
        endfunction
    endclass

    KeyMatrixScoreboard scoreboard = new();

    keyboard_matrix_scan dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // first_key, second_key, row_select
        .s_axis_tuser  (s_axis_tuser),   // mode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // column_data, zero fill
    );

    always #6 clk = ~clk;

    // Receiver backpressure, redrawn every cycle.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= out_idle_pct);

    // Handshake signals only change at the rising edge, so the falling edge
    // shows exactly what the next rising edge will see.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                scoreboard.check_column(m_axis_tdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, no beat moved", $time);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Entered and left at a rising edge; the beat is taken at the edge it returns on.
    task automatic send_command(input logic [1:0] mode, input logic [7:0] first_code,
                                input logic [7:0] second_code, input logic [7:0] row_sel);
        bit taken;
        while ($urandom_range(99) < in_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row_sel, second_code, first_code};
        s_axis_tuser  <= mode;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        scoreboard.note_command(mode, first_code, second_code, row_sel);
    endtask

    function automatic logic [7:0] pick_key();
        if ($urandom_range(99) < 80)
            return KEY_LAYOUT[$urandom_range(39)];
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_rows();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return 8'($urandom_range(255));
        if (pick < 80)
            return ~(8'h80 >> $urandom_range(7));   // single row
        if (pick < 90)
            return 8'h00;
        return 8'hff;
    endfunction

    task automatic run_directed();
        send_command(MODE_READ, 8'h00, 8'h00, 8'hff);    // nothing selected
        send_command(MODE_READ, 8'hff, 8'hff, 8'h00);    // all rows, idle matrix
        send_command(MODE_PRESS, "E", "C", 8'hff);       // enter and caps shift
        send_command(MODE_READ, 8'h00, 8'h00, 8'hbf);    // row 1
        send_command(MODE_READ, 8'h00, 8'h00, 8'hfe);    // row 7
        send_command(MODE_PRESS, " ", "S", 8'h00);       // space and symbol shift
        send_command(MODE_READ, 8'h00, 8'h00, 8'h7f);    // row 0
        send_command(MODE_PRESS, "a", "a", 8'h5a);       // same key twice
        send_command(MODE_READ, 8'h00, 8'h00, 8'hfd);    // row 6
        send_command(MODE_PRESS, 8'h00, 8'hff, 8'h00);   // unknown codes
        send_command(MODE_PRESS, 8'h80, 8'h7f, 8'hff);   // unknown codes
        send_command(MODE_READ, 8'h00, 8'h00, 8'h00);
        send_command(MODE_RELEASE, "a", 8'h00, 8'h00);   // one key let go
        send_command(MODE_READ, 8'h00, 8'h00, 8'hfd);
        send_command(MODE_PRESS, "1", "0", 8'hff);
        send_command(MODE_PRESS, "q", "p", 8'hff);
        send_command(MODE_PRESS, "g", "v", 8'hff);
        send_command(MODE_READ, 8'h00, 8'h00, 8'h00);
        send_command(MODE_RELEASE, "1", 8'hff, 8'h00);   // known plus unknown
        send_command(MODE_READ, 8'h00, 8'h00, 8'hf7);    // row 4
        send_command(MODE_UNUSED, "2", "3", 8'h00);      // ignored mode
        send_command(MODE_READ, 8'h00, 8'h00, 8'hf7);
        send_command(MODE_RELEASE, 8'h00, 8'h00, 8'hff); // release everything
        send_command(MODE_READ, 8'h00, 8'h00, 8'h00);
        send_command(MODE_UNUSED, 8'hff, 8'hff, 8'hff);
    endtask

    task automatic run_random(input int count);
        int          pick;
        logic [1:0]  mode;
        logic [7:0]  first_code;
        logic [7:0]  second_code;
        for (int n = 0; n < count; n++)
        begin
            pick        = $urandom_range(99);
            first_code  = pick_key();
            second_code = ($urandom_range(3) == 0) ? 8'h00 : pick_key();
            if (pick < 30)
                mode = MODE_PRESS;
            else if (pick < 55)
            begin
                mode = MODE_RELEASE;
                if ($urandom_range(19) == 0)
                begin
                    first_code  = 8'h00;
                    second_code = 8'h00;
                end
            end
            else if (pick < 95)
                mode = MODE_READ;
            else
                mode = MODE_UNUSED;
            send_command(mode, first_code, second_code, pick_rows());
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 1: sender idles lightly, receiver often stalls
        in_idle_pct  = 16;
        out_idle_pct = 59;
        run_directed();
        run_random(PHASE_ITEMS);

        // phase 2: the other way round
        in_idle_pct  = 59;
        out_idle_pct = 16;
        run_random(PHASE_ITEMS);

        // phase 3: full rate on both sides
        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_random(PHASE_ITEMS);

        s_axis_tvalid <= 1'b0;
        while (scoreboard.owed_columns.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (scoreboard.mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
